FILE: hdl/macc_pkg.sv
// Shared types and constants for the multi-channel axle counter
package macc_pkg;

  // Channel and field widths
  localparam int MaxChannels = 8;
  localparam int NumRegs     = 8;
  localparam int CfgIdxW     = $clog2(NumRegs);
  localparam int AddrW       = 16;
  localparam int CountW      = 16;
  localparam int LevelW      = 4;
  localparam int TimerW      = 10;
  localparam int ChIdxW      = 3;
  localparam int PinW        = 8;
  localparam int RstAddrW    = 12;

  // Default build values
  localparam int DefChannels      = 8;
  localparam int DefDebounceLimit = 10;
  localparam int DefReportTicks   = 1000;

  // Per-lane control for one accepted item
  typedef struct packed {
    logic tick;
    logic clear;
    logic pin;
  } lane_ctrl_t;

  // Per-lane status towards the report stage
  typedef struct packed {
    logic              report;
    logic [CountW-1:0] total;
  } lane_stat_t;

endpackage

FILE: hdl/macc_in_if.sv
// Input channel: tick or reset command
interface macc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [macc_pkg::PinW-1:0]     pin_levels;
  logic [macc_pkg::RstAddrW-1:0] reset_address;

  modport source (output valid, action, pin_levels, reset_address, input ready);
  modport sink   (input valid, action, pin_levels, reset_address, output ready);
endinterface

FILE: hdl/macc_out_if.sv
// Output channel: one axle count report
interface macc_out_if;
  logic                        valid;
  logic                        ready;
  logic [macc_pkg::ChIdxW-1:0] channel_index;
  logic [macc_pkg::AddrW-1:0]  channel_address;
  logic [macc_pkg::CountW-1:0] axle_count;
  logic                        last;

  modport source (output valid, channel_index, channel_address, axle_count, last,
                  input ready);
  modport sink   (input valid, channel_index, channel_address, axle_count, last,
                  output ready);
endinterface

FILE: hdl/macc_lane.sv
// One sensor channel: debounce integrator, axle latch, totals and report timer
module macc_lane #(
  parameter int DEBOUNCE_LIMIT = macc_pkg::DefDebounceLimit,
  parameter int REPORT_TICKS   = macc_pkg::DefReportTicks
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  macc_pkg::lane_ctrl_t ctrl_i,
  output macc_pkg::lane_stat_t stat_o
);
  import macc_pkg::*;

  localparam logic [LevelW-1:0] Limit    = LevelW'(DEBOUNCE_LIMIT);
  localparam logic [TimerW-1:0] Ticks    = TimerW'(REPORT_TICKS);
  localparam logic [TimerW:0]   TicksExt = (TimerW + 1)'(REPORT_TICKS);
  localparam logic [TimerW:0]   TimerSat = (TimerW + 1)'(REPORT_TICKS + 1);

  logic [LevelW-1:0] level_q, level_d;
  logic              latched_q, latched_d;
  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] reported_q, reported_d;
  logic [TimerW-1:0] timer_q, timer_d;

  logic [LevelW:0]   level_inc;
  logic [CountW-1:0] total_inc;
  logic [TimerW-1:0] timer_mid;
  logic [TimerW:0]   timer_inc;
  logic              report;

  assign level_inc = {1'b0, level_q} + (LevelW + 1)'(1);
  assign total_inc = total_q + CountW'(1);

  // Next state for a tick or a clear
  always_comb begin
    level_d    = level_q;
    latched_d  = latched_q;
    total_d    = total_q;
    reported_d = reported_q;
    timer_d    = timer_q;
    timer_mid  = timer_q;
    timer_inc  = '0;
    report     = 1'b0;
    if (ctrl_i.clear) begin
      level_d    = '0;
      latched_d  = 1'b0;
      total_d    = '0;
      reported_d = '0;
    end else if (ctrl_i.tick) begin
      if (ctrl_i.pin) begin
        if (level_inc >= {1'b0, Limit}) begin
          level_d = Limit;
          if (!latched_q) begin
            total_d   = total_inc;
            latched_d = 1'b1;
            // first axle makes the timer expire on this tick
            timer_mid = (total_inc == CountW'(1)) ? Ticks : '0;
          end
        end else begin
          level_d = level_inc[LevelW-1:0];
        end
      end else begin
        if (level_q != '0) begin
          level_d = level_q - LevelW'(1);
        end else begin
          latched_d = 1'b0;
        end
      end
      // advance timer, saturating one past the report limit
      timer_inc = {1'b0, timer_mid} + (TimerW + 1)'(1);
      timer_d   = (timer_inc > TimerSat) ? TimerSat[TimerW-1:0] : timer_inc[TimerW-1:0];
      report    = (timer_inc > TicksExt) && (total_d > reported_q);
      if (report) begin
        reported_d = total_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      latched_q  <= 1'b0;
      total_q    <= '0;
      reported_q <= '0;
      timer_q    <= '0;
    end else begin
      level_q    <= level_d;
      latched_q  <= latched_d;
      total_q    <= total_d;
      reported_q <= reported_d;
      timer_q    <= timer_d;
    end
  end

  assign stat_o.report = report;
  assign stat_o.total  = total_q;

endmodule

FILE: hdl/macc_merge.sv
// Report merge: collects lane report flags and issues them in channel order
module macc_merge #(
  parameter int CHANNELS = macc_pkg::DefChannels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  macc_pkg::lane_stat_t          stat_i [CHANNELS],
  input  logic [macc_pkg::AddrW-1:0]    addr_i [CHANNELS],
  output logic                          busy_o,
  macc_out_if.source                    out_o
);
  import macc_pkg::*;

  logic [CHANNELS-1:0] pend_q, pend_d;
  logic [CHANNELS-1:0] sel_mask;
  logic [ChIdxW-1:0]   sel_idx;
  logic [CountW-1:0]   sel_total;
  logic [AddrW-1:0]    sel_addr;
  logic                adv;

  logic              ovalid_q, ovalid_d;
  logic [ChIdxW-1:0] idx_q, idx_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              last_q, last_d;

  // Lowest pending channel
  always_comb begin
    sel_mask  = '0;
    sel_idx   = '0;
    sel_total = '0;
    sel_addr  = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (pend_q[c]) begin
        sel_mask  = '0;
        sel_mask[c] = 1'b1;
        sel_idx   = ChIdxW'(c);
        sel_total = stat_i[c].total;
        sel_addr  = addr_i[c];
      end
    end
  end

  // Output register moves on when empty or taken
  assign adv = !ovalid_q || out_o.ready;

  always_comb begin
    pend_d   = pend_q;
    ovalid_d = ovalid_q;
    idx_d    = idx_q;
    addr_d   = addr_q;
    count_d  = count_q;
    last_d   = last_q;
    if (adv) begin
      ovalid_d = (pend_q != '0);
      idx_d    = sel_idx;
      addr_d   = sel_addr;
      count_d  = sel_total;
      last_d   = ((pend_q & ~sel_mask) == '0);
      pend_d   = pend_q & ~sel_mask;
    end
    if (load_i) begin
      pend_d = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pend_d[c] = stat_i[c].report;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Report payload
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    addr_q  <= addr_d;
    count_q <= count_d;
    last_q  <= last_d;
  end

  assign busy_o                = (pend_q != '0);
  assign out_o.valid           = ovalid_q;
  assign out_o.channel_index   = idx_q;
  assign out_o.channel_address = addr_q;
  assign out_o.axle_count      = count_q;
  assign out_o.last            = last_q;

endmodule

FILE: hdl/multi_channel_axle_counter_core.sv
// Top level of the multi-channel axle counter
//
//  Channel   Direction  Transfer carries
//  in_i      sink       action, pin_levels, reset_address
//  out_o     source     channel_index, channel_address, axle_count, last
//  cfg_*_i   write      channel address register index and value
//
// All lanes update in the cycle an item is accepted. A tick that reports
// channels keeps the input stalled while the merge stage drains those reports
// into the output register, one report per cycle while out_o is ready; items
// that report nothing do not stall the input. The last report may still wait in
// the output register while the next item is taken. Reset clears all counters;
// addresses return to 1 .. 8.
module multi_channel_axle_counter_core #(
  parameter int CHANNELS       = macc_pkg::DefChannels,
  parameter int DEBOUNCE_LIMIT = macc_pkg::DefDebounceLimit,
  parameter int REPORT_TICKS   = macc_pkg::DefReportTicks
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  macc_in_if.sink                       in_i,
  macc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [macc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [macc_pkg::AddrW-1:0]    cfg_wdata_i
);
  import macc_pkg::*;

  logic [AddrW-1:0]    cfg_addr_q [NumRegs];
  logic [AddrW-1:0]    lane_addr  [CHANNELS];
  lane_ctrl_t          lane_ctrl  [CHANNELS];
  lane_stat_t          lane_stat  [CHANNELS];
  logic [CHANNELS-1:0] clr_sel;
  logic [AddrW-1:0]    rst_addr;
  logic                busy;
  logic                in_xfer;

  // Channel address registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) begin
        cfg_addr_q[r] <= AddrW'(r + 1);
      end
    end else if (cfg_we_i) begin
      cfg_addr_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign in_i.ready = !busy;
  assign in_xfer    = in_i.valid && !busy;

  // Reset command: lowest channel whose address matches
  assign rst_addr = AddrW'({1'b0, in_i.reset_address} + (RstAddrW + 1)'(1));

  always_comb begin
    clr_sel = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (cfg_addr_q[c] == rst_addr) begin
        clr_sel    = '0;
        clr_sel[c] = 1'b1;
      end
    end
  end

  // Lanes
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    assign lane_addr[c]       = cfg_addr_q[c];
    assign lane_ctrl[c].tick  = in_xfer && !in_i.action;
    assign lane_ctrl[c].clear = in_xfer && in_i.action && clr_sel[c];
    assign lane_ctrl[c].pin   = in_i.pin_levels[c];

    macc_lane #(
      .DEBOUNCE_LIMIT(DEBOUNCE_LIMIT),
      .REPORT_TICKS  (REPORT_TICKS)
    ) u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(lane_ctrl[c]),
      .stat_o(lane_stat[c])
    );
  end

  // Report merge
  macc_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(in_xfer && !in_i.action),
    .stat_i(lane_stat),
    .addr_i(lane_addr),
    .busy_o(busy),
    .out_o (out_o)
  );

`ifndef SYNTH
  // a reset command never leaves reports queued
  a_rst_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.action) |=> !busy)
    else $error("reset command left reports pending");

  // a report that is not the last is followed straight away by another
  a_report_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=> out_o.valid)
    else $error("report sequence broken before last");

  // a report that is not the last implies more reports still queued
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> busy)
    else $error("non-final report with nothing queued");
`endif

endmodule

FILE: tb/macc_checker.sv
`timescale 1ns / 100ps
// Testbench types and the checker that predicts and compares axle count reports
package axle_tb_pkg;
  import macc_pkg::*;

  // Item kinds on the input channel
  typedef enum logic {
    ActTick  = 1'b0,
    ActReset = 1'b1
  } action_e;

  // One axle count report as seen on the output channel
  typedef struct packed {
    logic [ChIdxW-1:0] channel;
    logic [AddrW-1:0]  address;
    logic [CountW-1:0] count;
    logic              last;
  } axle_report_t;
endpackage

module macc_checker #(
  parameter int CHANNELS       = macc_pkg::DefChannels,
  parameter int DEBOUNCE_LIMIT = macc_pkg::DefDebounceLimit,
  parameter int REPORT_TICKS   = macc_pkg::DefReportTicks
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  macc_in_if                           in_i,
  macc_out_if                          out_i,
  input  logic                         cfg_we_i,
  input  logic [macc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [macc_pkg::AddrW-1:0]   cfg_wdata_i,
  output int                           mismatches_o,
  output int                           outstanding_o,
  output int                           reports_o
);
  import macc_pkg::*;
  import axle_tb_pkg::*;

  // Own copy of the per-channel state and the address registers
  logic [AddrW-1:0]  chan_addr [NumRegs];
  logic [LevelW-1:0] level     [MaxChannels];
  logic              latched   [MaxChannels];
  logic [CountW-1:0] total     [MaxChannels];
  logic [CountW-1:0] reported  [MaxChannels];
  logic [TimerW-1:0] timer     [MaxChannels];

  axle_report_t expected_reports [$];

  task automatic restart_counters();
    for (int i = 0; i < NumRegs; i++) chan_addr[i] = AddrW'(i + 1);
    for (int ch = 0; ch < MaxChannels; ch++) begin
      level[ch]    = '0;
      latched[ch]  = 1'b0;
      total[ch]    = '0;
      reported[ch] = '0;
      timer[ch]    = '0;
    end
    expected_reports.delete();
  endtask

  // Reset command: lowest channel at address + 1 loses its counts, timer kept
  task automatic clear_by_address(input logic [RstAddrW-1:0] raddr);
    logic [AddrW-1:0] target;
    bit               found;
    target = AddrW'(raddr) + AddrW'(1);
    found  = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (!found && chan_addr[ch] == target) begin
        level[ch]    = '0;
        latched[ch]  = 1'b0;
        total[ch]    = '0;
        reported[ch] = '0;
        found        = 1'b1;
      end
    end
  endtask

  // Tick: debounce every pin, advance the timers, queue the due reports
  task automatic count_axles(input logic [PinW-1:0] pins);
    axle_report_t batch [MaxChannels];
    int           n;
    int           lvl;
    int           t;
    n = 0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (pins[ch]) begin
        lvl = int'(level[ch]) + 1;
        if (lvl >= DEBOUNCE_LIMIT) begin
          lvl = DEBOUNCE_LIMIT;
          if (!latched[ch]) begin
            total[ch]   = total[ch] + CountW'(1);
            latched[ch] = 1'b1;
            // first axle reports at once, later ones restart the wait
            timer[ch]   = (total[ch] == CountW'(1)) ? TimerW'(REPORT_TICKS) : '0;
          end
        end
        level[ch] = LevelW'(lvl);
      end else if (level[ch] != '0) begin
        level[ch] = level[ch] - LevelW'(1);
      end else begin
        latched[ch] = 1'b0;
      end
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      t = int'(timer[ch]) + 1;
      if (t > REPORT_TICKS + 1) t = REPORT_TICKS + 1;
      timer[ch] = TimerW'(t);
      if (t > REPORT_TICKS && total[ch] > reported[ch]) begin
        batch[n] = '{channel: ChIdxW'(ch), address: chan_addr[ch],
                     count: total[ch], last: 1'b0};
        reported[ch] = total[ch];
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      batch[i].last = (i == n - 1);
      expected_reports.push_back(batch[i]);
    end
  endtask

  task automatic compare_report();
    axle_report_t got;
    axle_report_t want;
    got = '{channel: out_i.channel_index, address: out_i.channel_address,
            count: out_i.axle_count, last: out_i.last};
    reports_o++;
    if (expected_reports.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("[%0t] unexpected report: ch %0d addr %h count %0d last %b",
                 $realtime, got.channel, got.address, got.count, got.last);
    end else begin
      want = expected_reports.pop_front();
      if (got.channel !== want.channel || got.address !== want.address ||
          got.count !== want.count || got.last !== want.last) begin
        mismatches_o++;
        if (mismatches_o <= 10)
          $display("[%0t] rpt %0d exp %0d/%h/%0d/%b got %0d/%h/%0d/%b",
                   $realtime, reports_o, want.channel, want.address, want.count,
                   want.last, got.channel, got.address, got.count, got.last);
      end
    end
  endtask

  // Results are taken before the item of the same edge, which cannot have caused them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_counters();
      mismatches_o = 0;
      reports_o    = 0;
    end else begin
      if (out_i.valid && out_i.ready) compare_report();
      if (in_i.valid && in_i.ready) begin
        if (action_e'(in_i.action) == ActReset) clear_by_address(in_i.reset_address);
        else count_axles(in_i.pin_levels);
      end
      if (cfg_we_i) chan_addr[cfg_idx_i] = cfg_wdata_i;
    end
    outstanding_o = expected_reports.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus, ready pattern and the final verdict
module tb;
  import macc_pkg::*;
  import axle_tb_pkg::*;

  localparam int Channels      = DefChannels;
  localparam int DebounceLimit = DefDebounceLimit;
  localparam int ReportTicks   = DefReportTicks;
  localparam int StallLimit    = 2000;
  localparam int SettleCycles  = 16;
  localparam int RandomItems   = 360;
  localparam int MinReports    = 40;
  localparam int PhaseCap      = 4000;
  localparam int TopResetAddr  = 1 << RstAddrW;

  typedef enum int {
    RxFree,
    RxCoin,
    RxOneInFour,
    RxChoked
  } stall_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [AddrW-1:0]   cfg_wdata;

  int mismatches;
  int outstanding;
  int reports_seen;
  int items_sent  = 0;
  int burst_left  = 0;
  int quiet_cycles = 0;

  // Addresses as last programmed, used to aim reset commands
  logic [AddrW-1:0] addr_cfg [NumRegs];

  macc_in_if  in_ch ();
  macc_out_if out_ch ();

  multi_channel_axle_counter_core #(
    .CHANNELS      (Channels),
    .DEBOUNCE_LIMIT(DebounceLimit),
    .REPORT_TICKS  (ReportTicks)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  macc_checker #(
    .CHANNELS      (Channels),
    .DEBOUNCE_LIMIT(DebounceLimit),
    .REPORT_TICKS  (ReportTicks)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .reports_o    (reports_seen)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: ready follows a random mode, picked anew when its stretch runs out
  initial begin
    stall_mode_e mode;
    int          stretch;
    int          beat;
    out_ch.ready = 1'b0;
    mode    = RxFree;
    stretch = 0;
    beat    = 0;
    forever begin
      @(negedge clk_i);
      if (stretch == 0) begin
        mode    = stall_mode_e'($urandom_range(0, 3));
        stretch = $urandom_range(20, 200);
      end
      stretch--;
      beat++;
      case (mode)
        RxFree:      out_ch.ready <= 1'b1;
        RxCoin:      out_ch.ready <= ($urandom_range(0, 1) == 0);
        RxOneInFour: out_ch.ready <= (beat % 4 == 0);
        default:     out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // One transfer on the input channel, in bursts with random gaps between them
  task automatic send_item(input action_e act, input logic [PinW-1:0] pins,
                           input logic [RstAddrW-1:0] raddr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.pin_levels    <= pins;
    in_ch.reset_address <= raddr;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic tick(input logic [PinW-1:0] pins);
    send_item(ActTick, pins, RstAddrW'($urandom));
  endtask

  function automatic bit reachable(input int ch);
    return addr_cfg[ch] != '0 && int'(addr_cfg[ch]) <= TopResetAddr;
  endfunction

  task automatic clear_channel(input int ch);
    send_item(ActReset, PinW'($urandom), RstAddrW'(int'(addr_cfg[ch]) - 1));
  endtask

  // Hold the input until every expected report has come, then let the block settle
  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_addresses();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CfgIdxW'(i);
      cfg_wdata <= addr_cfg[i];
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Clear some of the masked channels, hold their pins high, then let them fall back
  task automatic axle_pass(input logic [PinW-1:0] mask, input int highs, input int lows);
    for (int ch = 0; ch < Channels; ch++)
      if (mask[ch] && reachable(ch) && $urandom_range(0, 3) != 0) clear_channel(ch);
    repeat (highs) tick(mask | (PinW'($urandom) & ~mask));
    repeat (lows) tick(PinW'($urandom) & ~mask);
  endtask

  task automatic random_sequence();
    logic [PinW-1:0] mask;
    int              pick;
    pick = $urandom_range(0, 9);
    mask = PinW'($urandom_range(1, 255));
    if (pick <= 5) begin
      axle_pass(mask, $urandom_range(DebounceLimit, DebounceLimit + 2),
                $urandom_range(DebounceLimit + 1, DebounceLimit + 3));
    end else if (pick == 6) begin
      // pulse too short to count
      axle_pass(mask, $urandom_range(1, DebounceLimit - 1),
                $urandom_range(0, DebounceLimit + 1));
    end else if (pick <= 8) begin
      repeat ($urandom_range(1, 6))
        send_item(action_e'($urandom_range(0, 1)), PinW'($urandom), RstAddrW'($urandom));
    end else begin
      drain($urandom_range(1, 4));
    end
  endtask

  // Stimulus and verdict
  initial begin
    int mark;
    in_ch.valid         = 1'b0;
    in_ch.action        = ActTick;
    in_ch.pin_levels    = '0;
    in_ch.reset_address = '0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    rst_ni              = 1'b0;
    for (int i = 0; i < NumRegs; i++) addr_cfg[i] = AddrW'(i + 1);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: no match at 4096, channel 0 cleared, first axle on all eight
    send_item(ActReset, 8'hFF, 12'hFFF);
    send_item(ActReset, 8'h00, 12'h000);
    repeat (DebounceLimit) tick(8'hFF);
    tick(8'h00);
    drain(SettleCycles);

    // Extreme and shared addresses: a reset hits only the lower of two channels
    addr_cfg = '{16'd4096, 16'd4096, 16'h0000, 16'hFFFF,
                 16'h8000, 16'd1, 16'hFFFF, 16'd4095};
    write_addresses();
    send_item(ActReset, 8'h00, 12'hFFF);
    repeat (DebounceLimit) tick(8'hFF);
    drain(SettleCycles);

    // Reachable addresses with one pair shared
    for (int i = 0; i < NumRegs; i++) addr_cfg[i] = AddrW'($urandom_range(1, TopResetAddr));
    addr_cfg[$urandom_range(4, 7)] = addr_cfg[$urandom_range(0, 3)];
    write_addresses();

    // Release all, then one fresh axle each
    repeat (DebounceLimit + 1) tick(8'h00);
    axle_pass(8'hFF, DebounceLimit, 0);

    for (int phase = 0; phase < 2; phase++) begin
      if (phase == 1) begin
        drain(SettleCycles);
        for (int i = 0; i < NumRegs; i++)
          addr_cfg[i] = ($urandom_range(0, 1) == 0) ? AddrW'($urandom)
                                                    : AddrW'($urandom_range(1, TopResetAddr));
        addr_cfg[0] = AddrW'($urandom_range(1, TopResetAddr));
        write_addresses();
      end
      mark = items_sent;
      while ((items_sent - mark < RandomItems / 2 ||
              (phase == 1 && reports_seen < MinReports)) &&
             items_sent - mark < PhaseCap)
        random_sequence();
    end

    drain(SettleCycles);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
